### hw/rtl/modular_inverse_ext_euclid_top_defines.svh
// Assertion macros for the modular inverse block
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle
`define MIE_ASSERT_SAME(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("modular inverse: same-cycle check failed");

// Condition implies consequence in the next cycle
`define MIE_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("modular inverse: next-cycle check failed");

`endif

### hw/rtl/mie_pkg.sv
package mie_pkg;

  // Operand width and derived widths
  localparam int WORD_BITS = 32;
  localparam int COEF_BITS = WORD_BITS + 1;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

### hw/rtl/mie_in_if.sv
interface mie_in_if;
  import mie_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] value;
  logic [WORD_BITS-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

### hw/rtl/mie_out_if.sv
interface mie_out_if;
  import mie_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] inverse;
  logic                 coprime;

  modport source (output valid, output inverse, output coprime, input ready);
  modport sink   (input valid, input inverse, input coprime, output ready);
endinterface

### hw/rtl/modular_inverse_ext_euclid_top.sv
// One shift-subtract divider, one quotient bit per cycle, serves the initial
// reduction and every Euclid step; one item is in work at a time.
// The result register frees the input early: a new item can be accepted while
// the last result waits to be taken.
// Reset (rst, synchronous, active high) clears the sequencer and output valid.
`include "modular_inverse_ext_euclid_top_defines.svh"

module modular_inverse_ext_euclid_top (
  input logic clk,
  input logic rst,
  mie_in_if.sink    operands,
  mie_out_if.source result
);
  import mie_pkg::*;

  state_t state;
  state_t state_next;

  logic                 reducing;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] mod;
  logic [WORD_BITS-1:0] num;
  logic [WORD_BITS-1:0] rem;
  logic [COEF_BITS-1:0] cu;
  logic [COEF_BITS-1:0] cv;
  logic [COEF_BITS-1:0] acc;
  logic [CNT_BITS-1:0]  cnt;

  logic                 out_valid;
  logic [WORD_BITS-1:0] out_inverse;
  logic                 out_coprime;

  logic                 accept;
  logic                 slot_free;
  logic                 last_bit;
  logic [WORD_BITS-1:0] den;
  logic [WORD_BITS:0]   p_ext;
  logic                 ge;
  logic [WORD_BITS:0]   p_sub;
  logic [WORD_BITS-1:0] b_next;
  logic [COEF_BITS-1:0] cu_norm;

  assign accept    = operands.valid && operands.ready;
  assign slot_free = !out_valid || result.ready;
  assign last_bit  = (cnt == CNT_BITS'(WORD_BITS - 1));

  // Shared shift-subtract step
  assign den   = reducing ? a : b;
  assign p_ext = {rem, num[WORD_BITS-1]};
  assign ge    = (p_ext >= {1'b0, den});
  assign p_sub = p_ext - {1'b0, den};

  // New divisor after a division: remainder, forced to zero for a zero modulus
  assign b_next = (reducing && (a == '0)) ? '0 : rem;

  // Negative coefficient folded into 0 .. modulus-1
  assign cu_norm = cu[COEF_BITS-1] ? (cu + {1'b0, mod}) : cu;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (last_bit) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (b_next == '0) state_next = ST_FINISH;
        else              state_next = ST_DIVIDE;
      end
      ST_FINISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          a        <= operands.modulus;
          mod      <= operands.modulus;
          num      <= operands.value;
          rem      <= '0;
          acc      <= '0;
          cnt      <= '0;
          cu       <= '0;
          cv       <= COEF_BITS'(1);
          reducing <= 1'b1;
        end
      end
      ST_DIVIDE: begin
        rem <= ge ? p_sub[WORD_BITS-1:0] : p_ext[WORD_BITS-1:0];
        num <= {num[WORD_BITS-2:0], 1'b0};
        // quotient times cv, built MSB first
        acc <= {acc[COEF_BITS-2:0], 1'b0} + (ge ? cv : '0);
        cnt <= cnt + CNT_BITS'(1);
      end
      ST_UPDATE: begin
        if (reducing) begin
          num <= a;
        end else begin
          a   <= b;
          num <= b;
          cu  <= cv;
          cv  <= cu - acc;
        end
        b        <= b_next;
        reducing <= 1'b0;
        rem      <= '0;
        acc      <= '0;
        cnt      <= '0;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && slot_free) begin
      out_coprime <= (a == WORD_BITS'(1));
      out_inverse <= (a == WORD_BITS'(1)) ? cu_norm[WORD_BITS-1:0] : '0;
    end
  end

  assign operands.ready = (state == ST_IDLE);
  assign result.valid   = out_valid;
  assign result.inverse = out_inverse;
  assign result.coprime = out_coprime;

  // Checks
  `MIE_ASSERT_NEXT(a_accept_starts_reduce, accept, (state == ST_DIVIDE) && reducing)
  `MIE_ASSERT_NEXT(a_finish_posts_item, (state == ST_FINISH) && slot_free, out_valid)
  `MIE_ASSERT_SAME(a_euclid_divisor_nonzero, (state == ST_DIVIDE) && !reducing, b != '0)

endmodule
